@@ src/csb_pkg.sv @@
// Package for the counting semaphore bank: request and result types, status and
// operation codes, and default sizes. No dependencies.
package csb_pkg;

  localparam int PID_W  = 8;
  localparam int SID_W  = 3;
  localparam int STAT_W = 3;

  localparam int NUM_SEMAPHORES_DEF = 6;
  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int COUNT_MAX_DEF      = 15;
  localparam int INIT_COUNT         = 1;
  localparam int INIT_COUNT_LAST    = 4;

  typedef enum logic {
    OP_WAIT   = 1'b0,
    OP_SIGNAL = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ACQUIRED = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_RELEASED = 3'd2,
    ST_WOKE     = 3'd3,
    ST_BAD_ID   = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef struct packed {
    op_t              operation;
    logic [PID_W-1:0] pid;
    logic [SID_W-1:0] sem_id;
  } request_t;

  typedef struct packed {
    status_t          status;
    logic [PID_W-1:0] blocked_pid;
    logic [PID_W-1:0] woken_pid;
  } result_t;

endpackage

@@ src/csb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module csb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/counting_semaphore_bank.sv @@
// Bank of counting semaphores, each with a bounded FIFO ring of waiting pids.
// Depends on csb_pkg and csb_ram (the shared ring storage for all semaphores).
// The result strobe (done) is registered through s1_valid and then done_q after the request is
// accepted; one request is accepted every cycle while busy is low, and the receiver cannot stall.
// The per-semaphore count, head and tail registers are written while the request is in s1, so
// back-to-back requests to the same semaphore see each other's effects.
// Reset: counts go to 1 (the last semaphore to 4), all rings empty; busy is high
// while rst is asserted. The ring storage is not cleared and needs no clearing pass.
module counting_semaphore_bank #(
  parameter int NUM_SEMAPHORES = csb_pkg::NUM_SEMAPHORES_DEF,
  parameter int QUEUE_DEPTH    = csb_pkg::QUEUE_DEPTH_DEF,
  parameter int COUNT_MAX      = csb_pkg::COUNT_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  csb_pkg::request_t request,
  output logic              done,
  output csb_pkg::result_t  result
);

  localparam int SEM_W    = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int MAG      = (QUEUE_DEPTH > COUNT_MAX + 1) ? QUEUE_DEPTH : COUNT_MAX + 1;
  localparam int CNT_W    = $clog2(MAG) + 1;
  localparam int RAM_D    = NUM_SEMAPHORES * QUEUE_DEPTH;
  localparam int ADDR_W   = (RAM_D > 1) ? $clog2(RAM_D) : 1;
  localparam logic signed [CNT_W-1:0] CNT_FLOOR = CNT_W'(-QUEUE_DEPTH);
  localparam logic signed [CNT_W-1:0] CNT_CEIL  = CNT_W'(COUNT_MAX);
  localparam logic [PTR_W-1:0]        PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);

  function automatic logic signed [CNT_W-1:0] start_count(int s);
    int c;
    begin
      c = (s == NUM_SEMAPHORES - 1) ? csb_pkg::INIT_COUNT_LAST : csb_pkg::INIT_COUNT;
      if (c > COUNT_MAX) begin
        c = COUNT_MAX;
      end
      return CNT_W'(c);
    end
  endfunction

  function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  logic                    s1_valid;
  csb_pkg::request_t       s1_req;
  logic signed [CNT_W-1:0] cnt  [NUM_SEMAPHORES];
  logic [PTR_W-1:0]        head [NUM_SEMAPHORES];
  logic [PTR_W-1:0]        tail [NUM_SEMAPHORES];

  logic                    done_q;
  csb_pkg::status_t        st_q;
  logic [csb_pkg::PID_W-1:0] blk_q;
  logic [csb_pkg::PID_W-1:0] ram_rdata;

  logic                    sid_ok;
  logic [SEM_W-1:0]        sid;
  logic signed [CNT_W-1:0] cnt_sel;
  logic [PTR_W-1:0]        head_sel;
  logic [PTR_W-1:0]        tail_sel;
  logic signed [CNT_W-1:0] cnt_next;
  logic                    cnt_upd;
  logic                    push;
  logic                    pop;
  csb_pkg::status_t        st_next;
  logic [csb_pkg::PID_W-1:0] blk_next;
  logic [ADDR_W-1:0]       waddr;
  logic [ADDR_W-1:0]       raddr;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    if (start && !busy) begin
      s1_req <= request;
    end
  end

  always_comb begin
    sid_ok   = int'(s1_req.sem_id) < NUM_SEMAPHORES;
    sid      = sid_ok ? SEM_W'(s1_req.sem_id) : '0;
    cnt_sel  = cnt[sid];
    head_sel = head[sid];
    tail_sel = tail[sid];
    cnt_next = cnt_sel;
    cnt_upd  = 1'b0;
    push     = 1'b0;
    pop      = 1'b0;
    blk_next = '0;
    st_next  = csb_pkg::ST_BAD_ID;
    if (!sid_ok) begin
      st_next = csb_pkg::ST_BAD_ID;
    end else if (s1_req.operation == csb_pkg::OP_WAIT) begin
      if (cnt_sel > 0) begin
        cnt_next = cnt_sel - 1'b1;
        cnt_upd  = 1'b1;
        st_next  = csb_pkg::ST_ACQUIRED;
      end else if (cnt_sel <= CNT_FLOOR) begin
        st_next = csb_pkg::ST_FULL;
      end else begin
        cnt_next = cnt_sel - 1'b1;
        cnt_upd  = 1'b1;
        push     = 1'b1;
        blk_next = s1_req.pid;
        st_next  = csb_pkg::ST_QUEUED;
      end
    end else begin
      if (cnt_sel < 0) begin
        cnt_next = cnt_sel + 1'b1;
        cnt_upd  = 1'b1;
        pop      = 1'b1;
        st_next  = csb_pkg::ST_WOKE;
      end else begin
        if (cnt_sel < CNT_CEIL) begin
          cnt_next = cnt_sel + 1'b1;
          cnt_upd  = 1'b1;
        end
        st_next = csb_pkg::ST_RELEASED;
      end
    end
    waddr = ADDR_W'(sid) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_sel);
    raddr = ADDR_W'(sid) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SEMAPHORES; s++) begin
        cnt[s]  <= start_count(s);
        head[s] <= '0;
        tail[s] <= '0;
      end
    end else if (s1_valid) begin
      if (cnt_upd) begin
        cnt[sid] <= cnt_next;
      end
      if (push) begin
        tail[sid] <= ring_next(tail_sel);
      end
      if (pop) begin
        head[sid] <= ring_next(head_sel);
      end
    end
  end

  csb_ram #(
    .WIDTH (csb_pkg::PID_W),
    .DEPTH (RAM_D)
  ) u_ring (
    .clk   (clk),
    .we    (s1_valid && push),
    .waddr (waddr),
    .wdata (s1_req.pid),
    .re    (s1_valid && pop),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid;
    end
    st_q  <= st_next;
    blk_q <= blk_next;
  end

  assign done = done_q;

  always_comb begin
    result.status      = st_q;
    result.blocked_pid = blk_q;
    result.woken_pid   = (st_q == csb_pkg::ST_WOKE) ? ram_rdata : '0;
  end

  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> done)
    else $error("request in flight produced no result");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    !s1_valid |=> !done)
    else $error("result strobe without a request");

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    s1_valid && sid_ok |-> (cnt_sel >= CNT_FLOOR && cnt_sel <= CNT_CEIL))
    else $error("semaphore count out of range");

  a_empty_ring : assert property (@(posedge clk) disable iff (rst)
    s1_valid && sid_ok && cnt_sel >= 0 |-> head_sel == tail_sel)
    else $error("ring holds waiters while count is not negative");

  a_partial_ring : assert property (@(posedge clk) disable iff (rst)
    s1_valid && sid_ok && cnt_sel < 0 && cnt_sel > CNT_FLOOR |-> head_sel != tail_sel)
    else $error("ring empty or full while count shows waiters");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for counting_semaphore_bank: drives wait and signal requests and
// compares every result against a predictor of counts and per-semaphore FIFO wait rings.
// Depends on csb_pkg and the counting_semaphore_bank RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEM        = csb_pkg::NUM_SEMAPHORES_DEF;
  localparam int QDEPTH      = csb_pkg::QUEUE_DEPTH_DEF;
  localparam int CMAX        = csb_pkg::COUNT_MAX_DEF;
  localparam int ITEMS       = 1400;
  localparam int CYCLE_LIMIT = 200000;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  csb_pkg::request_t request;
  logic              done;
  csb_pkg::result_t  result;

  counting_semaphore_bank u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  int         sem_level [NSEM];
  logic [7:0] wait_ring [NSEM][QDEPTH];
  int         ring_head [NSEM];
  int         ring_tail [NSEM];

  csb_pkg::result_t pending_results[$];
  int      sent_count;
  int      error_count;
  int      cycle_count;
  int      status_seen [8];
  bit      quiet;

  function automatic void reset_semaphores();
    for (int s = 0; s < NSEM; s++) begin
      sem_level[s] = (s == NSEM - 1) ? csb_pkg::INIT_COUNT_LAST : csb_pkg::INIT_COUNT;
      if (sem_level[s] > CMAX) begin
        sem_level[s] = CMAX;
      end
      ring_head[s] = 0;
      ring_tail[s] = 0;
    end
  endfunction

  function automatic csb_pkg::result_t semaphore_outcome(csb_pkg::request_t req);
    csb_pkg::result_t res;
    int      s;
    res.status      = csb_pkg::ST_BAD_ID;
    res.blocked_pid = '0;
    res.woken_pid   = '0;
    s = int'(req.sem_id);
    if (s >= NSEM) begin
      return res;
    end
    if (req.operation == csb_pkg::OP_WAIT) begin
      if (sem_level[s] > 0) begin
        sem_level[s]--;
        res.status = csb_pkg::ST_ACQUIRED;
      end else if (sem_level[s] <= -QDEPTH) begin
        res.status = csb_pkg::ST_FULL;
      end else begin
        sem_level[s]--;
        wait_ring[s][ring_tail[s]] = req.pid;
        ring_tail[s] = (ring_tail[s] == QDEPTH - 1) ? 0 : ring_tail[s] + 1;
        res.blocked_pid = req.pid;
        res.status = csb_pkg::ST_QUEUED;
      end
    end else begin
      if (sem_level[s] < 0) begin
        sem_level[s]++;
        res.woken_pid = wait_ring[s][ring_head[s]];
        ring_head[s] = (ring_head[s] == QDEPTH - 1) ? 0 : ring_head[s] + 1;
        res.status = csb_pkg::ST_WOKE;
      end else begin
        if (sem_level[s] < CMAX) begin
          sem_level[s]++;
        end
        res.status = csb_pkg::ST_RELEASED;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    error_count++;
    $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin : result_check
    csb_pkg::result_t want;
    if (!rst) begin
      if (done === 1'b1) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, pending count", 0, 1);
        end else begin
          want = pending_results.pop_front();
          status_seen[want.status]++;
          if (result.status !== want.status) begin
            report_mismatch("status", want.status, result.status);
          end
          if (result.blocked_pid !== want.blocked_pid) begin
            report_mismatch("blocked_pid", want.blocked_pid, result.blocked_pid);
          end
          if (result.woken_pid !== want.woken_pid) begin
            report_mismatch("woken_pid", want.woken_pid, result.woken_pid);
          end
        end
      end else if (done !== 1'b0) begin
        report_mismatch("done strobe unknown", 0, 1);
      end
      if (start && !busy) begin
        pending_results.push_back(semaphore_outcome(request));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input csb_pkg::op_t op, input logic [7:0] pid,
                              input logic [2:0] sid);
    int gap;
    gap = 0;
    while (!quiet && $urandom_range(99) < 35) begin
      gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start             <= 1'b1;
    request.operation <= op;
    request.pid       <= pid;
    request.sem_id    <= sid;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    sent_count++;
    @(negedge clk);
  endtask

  task automatic drain_pause();
    start <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic test_bad_ids();
    send_request(csb_pkg::OP_WAIT, 8'hFF, 3'd6);
    send_request(csb_pkg::OP_SIGNAL, 8'h00, 3'd7);
    send_request(csb_pkg::OP_WAIT, 8'h00, 3'd7);
    send_request(csb_pkg::OP_SIGNAL, 8'hFF, 3'd6);
  endtask

  task automatic test_fifo_wake_order();
    send_request(csb_pkg::OP_WAIT, 8'h00, 3'd0);
    send_request(csb_pkg::OP_WAIT, 8'hFF, 3'd0);
    send_request(csb_pkg::OP_WAIT, 8'hA5, 3'd0);
    send_request(csb_pkg::OP_SIGNAL, 8'h5A, 3'd0);
    send_request(csb_pkg::OP_SIGNAL, 8'h00, 3'd0);
    send_request(csb_pkg::OP_SIGNAL, 8'hFF, 3'd0);
    send_request(csb_pkg::OP_SIGNAL, 8'h00, 3'd0);
  endtask

  task automatic test_count_saturation();
    for (int i = 0; i < CMAX - csb_pkg::INIT_COUNT_LAST + 1; i++) begin
      send_request(csb_pkg::OP_SIGNAL, 8'($urandom), 3'(NSEM - 1));
    end
  endtask

  task automatic test_queue_full();
    for (int i = 0; i < QDEPTH + 3; i++) begin
      send_request(csb_pkg::OP_WAIT, 8'($urandom), 3'd1);
    end
    for (int i = 0; i < QDEPTH + 1; i++) begin
      send_request(csb_pkg::OP_SIGNAL, 8'($urandom), 3'd1);
    end
  endtask

  // Bursts on one semaphore lean toward waits or signals, or mix both evenly, so the
  // counts swing between a full wait ring and saturation, with some requests scattered.
  task automatic test_random_bursts(input int target, input bit no_idle);
    int           wait_pct;
    int           len;
    logic [2:0]   sid;
    logic [2:0]   this_sid;
    csb_pkg::op_t op;
    quiet = no_idle;
    while (sent_count < target) begin
      sid = ($urandom_range(9) == 0) ? 3'($urandom_range(7, NSEM)) :
                                       3'($urandom_range(NSEM - 1));
      case ($urandom_range(2))
        0: wait_pct = 85;
        1: wait_pct = 15;
        default: wait_pct = 50;
      endcase
      len = $urandom_range(1, 40);
      for (int i = 0; i < len && sent_count < target; i++) begin
        op = ($urandom_range(99) < wait_pct) ? csb_pkg::OP_WAIT : csb_pkg::OP_SIGNAL;
        this_sid = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : sid;
        send_request(op, 8'($urandom), this_sid);
      end
      if ($urandom_range(11) == 0) begin
        drain_pause();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    quiet   = 1'b0;
    reset_semaphores();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_bad_ids();
    test_fifo_wake_order();
    test_count_saturation();
    test_queue_full();
    drain_pause();
    test_random_bursts(ITEMS / 2, 1'b0);
    test_random_bursts(ITEMS / 2 + 200, 1'b1);
    test_random_bursts(ITEMS, 1'b0);
    drain_pause();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("results never returned", 0, pending_results.size());
    end
    $display("Ran %0d requests in %0d cycles: %0d acquired, %0d queued, %0d released,",
             sent_count, cycle_count, status_seen[csb_pkg::ST_ACQUIRED],
             status_seen[csb_pkg::ST_QUEUED], status_seen[csb_pkg::ST_RELEASED]);
    $display("  %0d woke a waiter, %0d bad semaphore ids, %0d rejected on a full ring.",
             status_seen[csb_pkg::ST_WOKE], status_seen[csb_pkg::ST_BAD_ID],
             status_seen[csb_pkg::ST_FULL]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
